>>> design/sftc_pkg.sv
// ----------------------------------------------------------------------------
// sftc_pkg
// Request codes, status codes, field widths and the result record shared by
// the source filter and traffic counter and its channel interfaces.
// ----------------------------------------------------------------------------
package sftc_pkg;

    // Field widths of the input and result beats.
    localparam int REQ_W   = 3;
    localparam int ADDR_W  = 48;
    localparam int LEN_W   = 16;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 32;
    localparam int BYTES_W = 64;

    // Request codes carried in req_type; the remaining codes are ignored.
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD      = 3'd0,
        REQ_REMOVE   = 3'd1,
        REQ_RX_FRAME = 3'd2,
        REQ_TX_FRAME = 3'd3,
        REQ_TICK     = 3'd4
    } t_req_type;

    // Status codes returned with every result beat.
    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FAIL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    // One result beat.
    typedef struct packed {
        t_status              status;
        logic                 frame_accepted;
        logic [CNT_W-1:0]     seq_number;
        logic [CNT_W-1:0]     rep_round;
        logic [CNT_W-1:0]     rep_msgs_sent;
        logic [BYTES_W-1:0]   rep_bytes_sent;
        logic [CNT_W-1:0]     rep_total_msgs_sent;
        logic [BYTES_W-1:0]   rep_total_bytes_sent;
        logic [CNT_W-1:0]     rep_msgs_received;
        logic [BYTES_W-1:0]   rep_bytes_received;
        logic [CNT_W-1:0]     rep_total_msgs_received;
        logic [BYTES_W-1:0]   rep_total_bytes_received;
    } t_result;

endpackage

>>> design/sftc_if.sv
// ----------------------------------------------------------------------------
// sftc_in_if / sftc_out_if
// Valid/ready channels for request beats into the block and result beats
// out of it.
// ----------------------------------------------------------------------------
interface sftc_in_if import sftc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [ADDR_W-1:0]   address;
    logic [LEN_W-1:0]    byte_count;

    modport source (output valid, output req_type, output address,
                    output byte_count, input ready);
    modport sink   (input valid, input req_type, input address,
                    input byte_count, output ready);
endinterface

interface sftc_out_if import sftc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic                frame_accepted;
    logic [CNT_W-1:0]    seq_number;
    logic [CNT_W-1:0]    rep_round;
    logic [CNT_W-1:0]    rep_msgs_sent;
    logic [BYTES_W-1:0]  rep_bytes_sent;
    logic [CNT_W-1:0]    rep_total_msgs_sent;
    logic [BYTES_W-1:0]  rep_total_bytes_sent;
    logic [CNT_W-1:0]    rep_msgs_received;
    logic [BYTES_W-1:0]  rep_bytes_received;
    logic [CNT_W-1:0]    rep_total_msgs_received;
    logic [BYTES_W-1:0]  rep_total_bytes_received;

    modport source (output valid, output status, output frame_accepted,
                    output seq_number, output rep_round, output rep_msgs_sent,
                    output rep_bytes_sent, output rep_total_msgs_sent,
                    output rep_total_bytes_sent, output rep_msgs_received,
                    output rep_bytes_received, output rep_total_msgs_received,
                    output rep_total_bytes_received, input ready);
    modport sink   (input valid, input status, input frame_accepted,
                    input seq_number, input rep_round, input rep_msgs_sent,
                    input rep_bytes_sent, input rep_total_msgs_sent,
                    input rep_total_bytes_sent, input rep_msgs_received,
                    input rep_bytes_received, input rep_total_msgs_received,
                    input rep_total_bytes_received, output ready);
endinterface

>>> design/source_filter_traffic_counter.sv
// ----------------------------------------------------------------------------
// source_filter_traffic_counter
// Ignored-source table with frame filtering and sent/received traffic
// counters, reported and rolled over on each tick request.
// ----------------------------------------------------------------------------
// Usage:
// Request beats arrive on i_in (add or remove an ignored address, received
// frame, sent frame, tick). Every request beat yields exactly one result
// beat on o_out, in order. Unused request codes return "not a table
// request" with all other fields zero.
// An accepted request passes through one input register, then the table
// compare and counter update in a single pass into the result register,
// which drives o_out. Throughput is one beat per cycle while the receiver
// takes results; the rate is set by that single pass, in which the whole
// table is compared against the address in parallel.
// Reset clears all valid bits and counters and sets the round to one; the
// stored addresses are left as they are and are only read behind a valid
// bit. No clearing pass is needed, so a beat may be accepted straight
// after reset.
// When the receiver stalls the result is held, the input register still
// takes one more beat, and i_in.ready then drops until o_out moves.
// ----------------------------------------------------------------------------
module source_filter_traffic_counter
    import sftc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_BYTES    = 6
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sftc_in_if.sink   i_in,
    sftc_out_if.source o_out
);

    // Only the low address bytes take part in compares and are stored.
    localparam int KEY_W = (ADDR_BYTES * 8 >= ADDR_W) ? ADDR_W : ADDR_BYTES * 8;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Input register.
    logic               r_in_valid;
    logic [REQ_W-1:0]   r_req_type;
    logic [KEY_W-1:0]   r_key;
    logic [LEN_W-1:0]   r_byte_count;

    // Result register.
    logic               r_out_valid;
    t_result            r_res;
    t_result            n_res;

    // Address table and its valid bits.
    logic [KEY_W-1:0]         r_table [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_entry_valid;
    logic [TABLE_ENTRIES-1:0] n_entry_valid;

    // Counters.
    logic [CNT_W-1:0]   r_round,          n_round;
    logic [CNT_W-1:0]   r_seq,            n_seq;
    logic [CNT_W-1:0]   r_iv_msgs_sent,   n_iv_msgs_sent;
    logic [BYTES_W-1:0] r_iv_bytes_sent,  n_iv_bytes_sent;
    logic [CNT_W-1:0]   r_all_msgs_sent,  n_all_msgs_sent;
    logic [BYTES_W-1:0] r_all_bytes_sent, n_all_bytes_sent;
    logic [CNT_W-1:0]   r_iv_msgs_rx,     n_iv_msgs_rx;
    logic [BYTES_W-1:0] r_iv_bytes_rx,    n_iv_bytes_rx;
    logic [CNT_W-1:0]   r_all_msgs_rx,    n_all_msgs_rx;
    logic [BYTES_W-1:0] r_all_bytes_rx,   n_all_bytes_rx;

    logic                     out_free;
    logic                     advance;
    logic [TABLE_ENTRIES-1:0] hit_vec;
    logic                     hit;
    logic                     free_found;
    logic [IDX_W-1:0]         free_idx;
    logic                     tbl_we;
    logic [BYTES_W-1:0]       len_ext;

    // Handshake: the input register moves on whenever the result register
    // is empty or being emptied.
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input payload register.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req_type   <= i_in.req_type;
            r_key        <= i_in.address[KEY_W-1:0];
            r_byte_count <= i_in.byte_count;
        end
    end

    // Parallel compare of the key against every valid entry.
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_vec[i] = r_entry_valid[i] && (r_table[i] == r_key);
        end
        hit = |hit_vec;
    end

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_entry_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign len_ext = BYTES_W'(r_byte_count);

    // Result and next state for the request in the input register.
    always_comb begin
        n_res            = '0;
        n_res.status     = ST_NONE;
        n_entry_valid    = r_entry_valid;
        tbl_we           = 1'b0;
        n_round          = r_round;
        n_seq            = r_seq;
        n_iv_msgs_sent   = r_iv_msgs_sent;
        n_iv_bytes_sent  = r_iv_bytes_sent;
        n_all_msgs_sent  = r_all_msgs_sent;
        n_all_bytes_sent = r_all_bytes_sent;
        n_iv_msgs_rx     = r_iv_msgs_rx;
        n_iv_bytes_rx    = r_iv_bytes_rx;
        n_all_msgs_rx    = r_all_msgs_rx;
        n_all_bytes_rx   = r_all_bytes_rx;

        unique case (t_req_type'(r_req_type))
            REQ_ADD: begin
                n_res.status = ST_FAIL;
                if (!hit && free_found) begin
                    n_res.status            = ST_OK;
                    n_entry_valid[free_idx] = 1'b1;
                    tbl_we                  = 1'b1;
                end
            end
            REQ_REMOVE: begin
                n_res.status  = hit ? ST_OK : ST_FAIL;
                n_entry_valid = r_entry_valid & ~hit_vec;
            end
            REQ_RX_FRAME: begin
                if (!hit) begin
                    n_res.frame_accepted = 1'b1;
                    n_iv_msgs_rx         = r_iv_msgs_rx + 1'b1;
                    n_all_msgs_rx        = r_all_msgs_rx + 1'b1;
                    n_iv_bytes_rx        = r_iv_bytes_rx + len_ext;
                    n_all_bytes_rx       = r_all_bytes_rx + len_ext;
                end
            end
            REQ_TX_FRAME: begin
                n_res.seq_number = r_seq;
                n_seq            = r_seq + 1'b1;
                n_iv_msgs_sent   = r_iv_msgs_sent + 1'b1;
                n_all_msgs_sent  = r_all_msgs_sent + 1'b1;
                n_iv_bytes_sent  = r_iv_bytes_sent + len_ext;
                n_all_bytes_sent = r_all_bytes_sent + len_ext;
            end
            REQ_TICK: begin
                n_res.rep_round                = r_round;
                n_res.rep_msgs_sent            = r_iv_msgs_sent;
                n_res.rep_bytes_sent           = r_iv_bytes_sent;
                n_res.rep_total_msgs_sent      = r_all_msgs_sent;
                n_res.rep_total_bytes_sent     = r_all_bytes_sent;
                n_res.rep_msgs_received        = r_iv_msgs_rx;
                n_res.rep_bytes_received       = r_iv_bytes_rx;
                n_res.rep_total_msgs_received  = r_all_msgs_rx;
                n_res.rep_total_bytes_received = r_all_bytes_rx;
                n_round                        = r_round + 1'b1;
                n_iv_msgs_sent                 = '0;
                n_iv_bytes_sent                = '0;
                n_iv_msgs_rx                   = '0;
                n_iv_bytes_rx                  = '0;
            end
            default: begin
            end
        endcase
    end

    // State registers, updated as each request leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid    <= '0;
            r_round          <= CNT_W'(1);
            r_seq            <= '0;
            r_iv_msgs_sent   <= '0;
            r_iv_bytes_sent  <= '0;
            r_all_msgs_sent  <= '0;
            r_all_bytes_sent <= '0;
            r_iv_msgs_rx     <= '0;
            r_iv_bytes_rx    <= '0;
            r_all_msgs_rx    <= '0;
            r_all_bytes_rx   <= '0;
        end else if (advance) begin
            r_entry_valid    <= n_entry_valid;
            r_round          <= n_round;
            r_seq            <= n_seq;
            r_iv_msgs_sent   <= n_iv_msgs_sent;
            r_iv_bytes_sent  <= n_iv_bytes_sent;
            r_all_msgs_sent  <= n_all_msgs_sent;
            r_all_bytes_sent <= n_all_bytes_sent;
            r_iv_msgs_rx     <= n_iv_msgs_rx;
            r_iv_bytes_rx    <= n_iv_bytes_rx;
            r_all_msgs_rx    <= n_all_msgs_rx;
            r_all_bytes_rx   <= n_all_bytes_rx;
        end
    end

    // Address table write on a successful add.
    always_ff @(posedge i_clk) begin
        if (advance && tbl_we) begin
            r_table[free_idx] <= r_key;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    // Result beat onto the output channel.
    assign o_out.valid                    = r_out_valid;
    assign o_out.status                   = r_res.status;
    assign o_out.frame_accepted           = r_res.frame_accepted;
    assign o_out.seq_number               = r_res.seq_number;
    assign o_out.rep_round                = r_res.rep_round;
    assign o_out.rep_msgs_sent            = r_res.rep_msgs_sent;
    assign o_out.rep_bytes_sent           = r_res.rep_bytes_sent;
    assign o_out.rep_total_msgs_sent      = r_res.rep_total_msgs_sent;
    assign o_out.rep_total_bytes_sent     = r_res.rep_total_bytes_sent;
    assign o_out.rep_msgs_received        = r_res.rep_msgs_received;
    assign o_out.rep_bytes_received       = r_res.rep_bytes_received;
    assign o_out.rep_total_msgs_received  = r_res.rep_total_msgs_received;
    assign o_out.rep_total_bytes_received = r_res.rep_total_bytes_received;

    // A successful add fills exactly one more slot.
    a_add_fills_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (t_req_type'(r_req_type) == REQ_ADD) && (n_res.status == ST_OK)
        |=> $countones(r_entry_valid) == $past($countones(r_entry_valid)) + 1)
        else $error("successful add did not fill exactly one slot");

    // A successful remove frees exactly one slot, so entries never repeat.
    a_remove_frees_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (t_req_type'(r_req_type) == REQ_REMOVE) && (n_res.status == ST_OK)
        |=> $countones(r_entry_valid) == $past($countones(r_entry_valid)) - 1)
        else $error("successful remove did not free exactly one slot");

    // A tick leaves every interval counter cleared and advances the round.
    a_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (t_req_type'(r_req_type) == REQ_TICK)
        |=> (r_iv_msgs_sent == '0) && (r_iv_bytes_sent == '0) &&
            (r_iv_msgs_rx == '0) && (r_iv_bytes_rx == '0) &&
            (r_round == $past(r_round) + 1'b1))
        else $error("tick did not clear the interval counters");

endmodule

>>> verif/sftc_result_monitor.sv
// ----------------------------------------------------------------------------
// sftc_result_monitor
// Watches the request and result channels of the source filter and traffic
// counter. It keeps its own copy of the ignored-address table and of every
// counter, works out the result of each accepted request beat, and compares
// each accepted result beat with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sftc_result_monitor
    import sftc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_BYTES    = 6
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sftc_in_if   i_req,
    sftc_out_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Only the low ADDR_BYTES bytes of an address take part in matching.
    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BYTES * 8 >= ADDR_W) ?
        {ADDR_W{1'b1}} : ((ADDR_W'(1) << (ADDR_BYTES * 8)) - ADDR_W'(1));

    // Shadow of the filter table.
    logic [ADDR_W-1:0]  ignored_src [TABLE_ENTRIES];
    logic               slot_used   [TABLE_ENTRIES];

    // Shadow of the round, sequence and traffic counters.
    logic [CNT_W-1:0]   round_no;
    logic [CNT_W-1:0]   next_seq;
    logic [CNT_W-1:0]   tx_iv_msgs;
    logic [BYTES_W-1:0] tx_iv_bytes;
    logic [CNT_W-1:0]   tx_all_msgs;
    logic [BYTES_W-1:0] tx_all_bytes;
    logic [CNT_W-1:0]   rx_iv_msgs;
    logic [BYTES_W-1:0] rx_iv_bytes;
    logic [CNT_W-1:0]   rx_all_msgs;
    logic [BYTES_W-1:0] rx_all_bytes;

    // Results predicted but not yet seen on the output channel.
    t_result            results_due [$];
    t_result            oldest_due;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Return the slot holding this address, or -1 when it is not ignored.
    function automatic int find_ignored(input logic [ADDR_W-1:0] key);
        int hit;
        hit = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit < 0 && slot_used[i] && ignored_src[i] == key) begin
                hit = i;
            end
        end
        return hit;
    endfunction

    // Work out the result of one request and update the shadow state.
    function automatic t_result predict_result(input logic [REQ_W-1:0]  req,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [LEN_W-1:0]  len);
        t_result           res;
        logic [ADDR_W-1:0] key;
        int                hit;
        int                free_slot;
        res        = '0;
        res.status = ST_NONE;
        key        = addr & ADDR_MASK;
        hit        = find_ignored(key);
        free_slot  = -1;
        case (req)
            REQ_ADD: begin
                // A duplicate or a full table leaves the table as it is.
                res.status = ST_FAIL;
                if (hit < 0) begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (free_slot < 0 && !slot_used[i]) begin
                            free_slot = i;
                        end
                    end
                    if (free_slot >= 0) begin
                        slot_used[free_slot]   = 1'b1;
                        ignored_src[free_slot] = key;
                        res.status             = ST_OK;
                    end
                end
            end
            REQ_REMOVE: begin
                if (hit >= 0) begin
                    slot_used[hit] = 1'b0;
                    res.status     = ST_OK;
                end else begin
                    res.status = ST_FAIL;
                end
            end
            REQ_RX_FRAME: begin
                // Frames from an ignored source are dropped without counting.
                if (hit < 0) begin
                    res.frame_accepted = 1'b1;
                    rx_iv_msgs++;
                    rx_all_msgs++;
                    rx_iv_bytes  += BYTES_W'(len);
                    rx_all_bytes += BYTES_W'(len);
                end
            end
            REQ_TX_FRAME: begin
                res.seq_number = next_seq;
                next_seq++;
                tx_iv_msgs++;
                tx_all_msgs++;
                tx_iv_bytes  += BYTES_W'(len);
                tx_all_bytes += BYTES_W'(len);
            end
            REQ_TICK: begin
                res.rep_round                = round_no;
                res.rep_msgs_sent            = tx_iv_msgs;
                res.rep_bytes_sent           = tx_iv_bytes;
                res.rep_total_msgs_sent      = tx_all_msgs;
                res.rep_total_bytes_sent     = tx_all_bytes;
                res.rep_msgs_received        = rx_iv_msgs;
                res.rep_bytes_received       = rx_iv_bytes;
                res.rep_total_msgs_received  = rx_all_msgs;
                res.rep_total_bytes_received = rx_all_bytes;
                round_no++;
                tx_iv_msgs  = '0;
                tx_iv_bytes = '0;
                rx_iv_msgs  = '0;
                rx_iv_bytes = '0;
            end
            default: begin
                // Spare request codes change nothing.
            end
        endcase
        return res;
    endfunction

    task automatic compare_field(input string              field,
                                 input logic [BYTES_W-1:0] want,
                                 input logic [BYTES_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            o_fail_count++;
        end
    endtask

    // Result beats are checked before the request beat of the same edge is
    // predicted; a request can never produce its result on the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_used[i]   = 1'b0;
                ignored_src[i] = '0;
            end
            round_no     = CNT_W'(1);
            next_seq     = '0;
            tx_iv_msgs   = '0;
            tx_iv_bytes  = '0;
            tx_all_msgs  = '0;
            tx_all_bytes = '0;
            rx_iv_msgs   = '0;
            rx_iv_bytes  = '0;
            rx_all_msgs  = '0;
            rx_all_bytes = '0;
            results_due.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (results_due.size() == 0) begin
                    $error("result beat arrived with no request outstanding");
                    o_fail_count++;
                end else begin
                    oldest_due = results_due.pop_front();
                    compare_field("status", oldest_due.status, i_rsp.status);
                    compare_field("frame_accepted", oldest_due.frame_accepted,
                                  i_rsp.frame_accepted);
                    compare_field("seq_number", oldest_due.seq_number,
                                  i_rsp.seq_number);
                    compare_field("rep_round", oldest_due.rep_round,
                                  i_rsp.rep_round);
                    compare_field("rep_msgs_sent", oldest_due.rep_msgs_sent,
                                  i_rsp.rep_msgs_sent);
                    compare_field("rep_bytes_sent", oldest_due.rep_bytes_sent,
                                  i_rsp.rep_bytes_sent);
                    compare_field("rep_total_msgs_sent",
                                  oldest_due.rep_total_msgs_sent,
                                  i_rsp.rep_total_msgs_sent);
                    compare_field("rep_total_bytes_sent",
                                  oldest_due.rep_total_bytes_sent,
                                  i_rsp.rep_total_bytes_sent);
                    compare_field("rep_msgs_received",
                                  oldest_due.rep_msgs_received,
                                  i_rsp.rep_msgs_received);
                    compare_field("rep_bytes_received",
                                  oldest_due.rep_bytes_received,
                                  i_rsp.rep_bytes_received);
                    compare_field("rep_total_msgs_received",
                                  oldest_due.rep_total_msgs_received,
                                  i_rsp.rep_total_msgs_received);
                    compare_field("rep_total_bytes_received",
                                  oldest_due.rep_total_bytes_received,
                                  i_rsp.rep_total_bytes_received);
                end
            end
            if (i_req.valid && i_req.ready) begin
                results_due.push_back(predict_result(i_req.req_type,
                                                     i_req.address,
                                                     i_req.byte_count));
            end
        end
        o_pending = results_due.size();
    end

endmodule

>>> verif/source_filter_traffic_counter_tb.sv
// ----------------------------------------------------------------------------
// source_filter_traffic_counter_tb
// Drives request beats into the source filter and traffic counter: a short
// directed opening that covers duplicates, the full table, absent removes,
// dropped frames, spare codes and ticks, then random traffic over a small
// address pool so that the table fills and drains. The sender works in
// bursts and the receiver stalls on its own pattern; a monitor beside the
// block predicts and checks every result beat.
// ----------------------------------------------------------------------------
module source_filter_traffic_counter_tb
    import sftc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = 16;
    localparam int ADDR_BYTES    = 6;
    localparam int POOL_SIZE     = 24;
    localparam int RANDOM_BEATS  = 800;
    localparam int DRAIN_EVERY   = 200;
    localparam int SETTLE_CYCLES = 8;

    // Request codes with no meaning to the block.
    localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } t_stall_mode;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   burst_left;
    int   beats_by_code [8];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    sftc_in_if  req_ch ();
    sftc_out_if rsp_ch ();

    source_filter_traffic_counter #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_BYTES    (ADDR_BYTES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    sftc_result_monitor #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_BYTES    (ADDR_BYTES)
    ) i_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock, 12 ns period.
    initial begin
        i_clk = 1'b0;
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    // Guard against a hung run.
    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // The receiver switches between no stalls, light and heavy stalling.
    initial begin : stall_pattern
        t_stall_mode mode;
        int          left;
        mode         = STALL_NONE;
        left         = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = t_stall_mode'($urandom_range(0, 2));
                left = $urandom_range(16, 80);
            end
            left--;
            case (mode)
                STALL_NONE:  rsp_ch.ready = 1'b1;
                STALL_LIGHT: rsp_ch.ready = ($urandom_range(0, 3) != 0);
                default:     rsp_ch.ready = ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    function automatic logic [ADDR_W-1:0] random_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Send one request beat and wait until it is accepted. A new burst
    // starts with a random gap, which is sometimes zero.
    task automatic send_beat(input logic [REQ_W-1:0]  req,
                             input logic [ADDR_W-1:0] addr,
                             input logic [LEN_W-1:0]  len);
        int gap;
        gap = 0;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 2) != 0) begin
                gap = $urandom_range(1, 6);
            end
        end
        burst_left--;
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.req_type   = req;
        req_ch.address    = addr;
        req_ch.byte_count = len;
        req_ch.valid      = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        beats_by_code[req]++;
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        int               pick;
        int               len_pick;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [REQ_W-1:0]  req;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = '0;
        req_ch.address    = '0;
        req_ch.byte_count = '0;
        i_rst_n           = 1'b0;
        burst_left        = 0;
        foreach (beats_by_code[i]) beats_by_code[i] = 0;

        // A small pool makes duplicates, hits and a full table likely.
        addr_pool[0] = '0;
        addr_pool[1] = {ADDR_W{1'b1}};
        for (int i = 2; i < POOL_SIZE; i++) begin
            addr_pool[i] = random_addr();
        end

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening: report straight after reset, frame extremes.
        send_beat(REQ_TICK, '0, '0);
        send_beat(REQ_RX_FRAME, addr_pool[0], {LEN_W{1'b1}});
        send_beat(REQ_TX_FRAME, addr_pool[1], {LEN_W{1'b1}});
        // Duplicate of the first table entry, then a dropped frame.
        send_beat(REQ_ADD, addr_pool[0], '0);
        send_beat(REQ_ADD, addr_pool[0], '0);
        send_beat(REQ_RX_FRAME, addr_pool[0], 16'd100);
        // Removing an address that was never added.
        send_beat(REQ_REMOVE, addr_pool[1], '0);
        // Spare codes with every address and length bit set.
        for (int c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++) begin
            send_beat(REQ_W'(c), {ADDR_W{1'b1}}, {LEN_W{1'b1}});
        end
        // Fill the table, then try one more.
        for (int i = 2; i <= TABLE_ENTRIES; i++) begin
            send_beat(REQ_ADD, addr_pool[i], '0);
        end
        send_beat(REQ_ADD, addr_pool[TABLE_ENTRIES + 1], '0);
        send_beat(REQ_TICK, '0, '0);

        // Random traffic, alternating between filling and draining phases.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % DRAIN_EVERY == 0) begin
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < (((n / 100) % 2 == 0) ? 35 : 10)) begin
                req = REQ_ADD;
            end else if (pick < 45) begin
                req = REQ_REMOVE;
            end else if (pick < 72) begin
                req = REQ_RX_FRAME;
            end else if (pick < 88) begin
                req = REQ_TX_FRAME;
            end else if (pick < 96) begin
                req = REQ_TICK;
            end else begin
                req = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
            end
            if ($urandom_range(0, 99) < 85) begin
                addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
                addr = random_addr();
            end
            len_pick = $urandom_range(0, 9);
            if (len_pick == 0) begin
                len = '0;
            end else if (len_pick == 1) begin
                len = {LEN_W{1'b1}};
            end else begin
                len = LEN_W'($urandom);
            end
            send_beat(req, addr, len);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d adds, %0d removes, %0d received and %0d sent frames,",
                 beats_by_code[REQ_ADD], beats_by_code[REQ_REMOVE],
                 beats_by_code[REQ_RX_FRAME], beats_by_code[REQ_TX_FRAME]);
        $display("%0d ticks and %0d spare-code requests, under bursty input and stalls.",
                 beats_by_code[REQ_TICK],
                 beats_by_code[REQ_SPARE_FIRST] + beats_by_code[REQ_SPARE_FIRST + 1]
                 + beats_by_code[REQ_SPARE_LAST]);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
design/sftc_pkg.sv
design/sftc_if.sv
design/source_filter_traffic_counter.sv
verif/sftc_result_monitor.sv
verif/source_filter_traffic_counter_tb.sv
